// File: sv/aracs_pkg.sv
package aracs_pkg;

    localparam int MARK_DEPTH_DEF = 8;
    localparam int MARK_DEPTH_MAX = 32;
    // Widths of the mark index and count fields in a command, sized for the largest buffer.
    localparam int MARK_IDX_W     = $clog2(MARK_DEPTH_MAX);
    localparam int MARK_CNT_W     = $clog2(MARK_DEPTH_MAX + 1);
    localparam int CP_W           = 21;

    localparam logic [CP_W-1:0] CP_LAM     = 21'h000644;
    localparam logic [CP_W-1:0] CP_TATWEEL = 21'h000640;
    localparam logic [CP_W-1:0] CP_ALEF_MADDA = 21'h000622;
    localparam logic [CP_W-1:0] CP_ALEF_HAMZA_ABOVE = 21'h000623;
    localparam logic [CP_W-1:0] CP_ALEF_HAMZA_BELOW = 21'h000625;
    localparam logic [CP_W-1:0] CP_ALEF = 21'h000627;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            text_end;
    } item_word_t;

    typedef struct packed {
        logic [CP_W-1:0] shaped_code;
        logic            run_last;
        logic            text_last;
        logic            mark_overflow;
    } result_word_t;

    typedef struct packed {
        logic        hit;
        logic        jf;
        logic        jb;
        logic [15:0] iso;
        logic [15:0] ini;
        logic [15:0] med;
        logic [15:0] fin;
    } form_t;

    // One command per accepted item: an optional mark store, then the results in order
    // first code, held marks, tail code, last code.
    typedef struct packed {
        logic                  store;
        logic [MARK_IDX_W-1:0] store_idx;
        logic [15:0]           store_data;
        logic                  has_a;
        logic [CP_W-1:0]       code_a;
        logic [MARK_CNT_W-1:0] n_marks;
        logic                  has_b;
        logic [CP_W-1:0]       code_b;
        logic                  has_c;
        logic [CP_W-1:0]       code_c;
        logic                  overflow;
        logic                  text_end;
    } cmd_t;

    function automatic form_t make_form(input logic [15:0] iso, input logic [15:0] ini,
                                        input logic [15:0] med, input logic [15:0] fin);
        form_t f;
        f.hit = 1'b1;
        f.iso = iso;
        f.ini = ini;
        f.med = med;
        f.fin = fin;
        f.jf  = (ini != 16'h0) || (med != 16'h0);
        f.jb  = (med != 16'h0) || (fin != 16'h0);
        return f;
    endfunction

    function automatic form_t form_lookup(input logic [CP_W-1:0] cp);
        form_t f;
        f = '0;
        case (cp)
            21'h0621: f = make_form(16'hFE80, 16'h0, 16'h0, 16'h0);
            21'h0622: f = make_form(16'hFE81, 16'h0, 16'h0, 16'hFE82);
            21'h0623: f = make_form(16'hFE83, 16'h0, 16'h0, 16'hFE84);
            21'h0624: f = make_form(16'hFE85, 16'h0, 16'h0, 16'hFE86);
            21'h0625: f = make_form(16'hFE87, 16'h0, 16'h0, 16'hFE88);
            21'h0626: f = make_form(16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A);
            21'h0627: f = make_form(16'hFE8D, 16'h0, 16'h0, 16'hFE8E);
            21'h0628: f = make_form(16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90);
            21'h0629: f = make_form(16'hFE93, 16'h0, 16'h0, 16'hFE94);
            21'h062A: f = make_form(16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96);
            21'h062B: f = make_form(16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A);
            21'h062C: f = make_form(16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E);
            21'h062D: f = make_form(16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2);
            21'h062E: f = make_form(16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6);
            21'h062F: f = make_form(16'hFEA9, 16'h0, 16'h0, 16'hFEAA);
            21'h0630: f = make_form(16'hFEAB, 16'h0, 16'h0, 16'hFEAC);
            21'h0631: f = make_form(16'hFEAD, 16'h0, 16'h0, 16'hFEAE);
            21'h0632: f = make_form(16'hFEAF, 16'h0, 16'h0, 16'hFEB0);
            21'h0633: f = make_form(16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2);
            21'h0634: f = make_form(16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6);
            21'h0635: f = make_form(16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA);
            21'h0636: f = make_form(16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE);
            21'h0637: f = make_form(16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2);
            21'h0638: f = make_form(16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6);
            21'h0639: f = make_form(16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA);
            21'h063A: f = make_form(16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE);
            21'h0640:
            begin
                // Tatweel keeps its own code but joins on both sides.
                f    = make_form(16'h0640, 16'h0, 16'h0, 16'h0);
                f.jf = 1'b1;
                f.jb = 1'b1;
            end
            21'h0641: f = make_form(16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2);
            21'h0642: f = make_form(16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6);
            21'h0643: f = make_form(16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA);
            21'h0644: f = make_form(16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE);
            21'h0645: f = make_form(16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2);
            21'h0646: f = make_form(16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6);
            21'h0647: f = make_form(16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA);
            21'h0648: f = make_form(16'hFEED, 16'h0, 16'h0, 16'hFEEE);
            21'h0649: f = make_form(16'hFEEF, 16'hFEF3, 16'hFEF4, 16'hFEF0);
            21'h064A: f = make_form(16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2);
            21'h0679: f = make_form(16'hFB66, 16'hFB68, 16'hFB69, 16'hFB67);
            21'h067E: f = make_form(16'hFB56, 16'hFB58, 16'hFB59, 16'hFB57);
            21'h0686: f = make_form(16'hFB7A, 16'hFB7C, 16'hFB7D, 16'hFB7B);
            21'h0688: f = make_form(16'hFB88, 16'h0, 16'h0, 16'hFB89);
            21'h0691: f = make_form(16'hFB8C, 16'h0, 16'h0, 16'hFB8D);
            21'h0698: f = make_form(16'hFB8A, 16'h0, 16'h0, 16'hFB8B);
            21'h06A9: f = make_form(16'hFB8E, 16'hFB90, 16'hFB91, 16'hFB8F);
            21'h06AF: f = make_form(16'hFB92, 16'hFB94, 16'hFB95, 16'hFB93);
            21'h06BA: f = make_form(16'hFB9E, 16'hFEE7, 16'hFEE8, 16'hFB9F);
            21'h06BE: f = make_form(16'hFBAA, 16'hFBAC, 16'hFBAD, 16'hFBAB);
            21'h06C1: f = make_form(16'hFBA6, 16'hFBA8, 16'hFBA9, 16'hFBA7);
            21'h06CC: f = make_form(16'hFEEF, 16'hFEF3, 16'hFEF4, 16'hFEF0);
            default:  f = '0;
        endcase
        return f;
    endfunction

    function automatic logic is_mark(input logic [CP_W-1:0] cp);
        logic m;
        case (cp)
            21'h0610, 21'h0612, 21'h0613, 21'h0614, 21'h0615, 21'h064B, 21'h064C, 21'h064D,
            21'h064E, 21'h064F, 21'h0650, 21'h0651, 21'h0652, 21'h0653, 21'h0654, 21'h0655,
            21'h0656, 21'h0657, 21'h0658, 21'h0670, 21'h06D6, 21'h06D7, 21'h06D8, 21'h06D9,
            21'h06DA, 21'h06DB, 21'h06DC, 21'h06DF, 21'h06E0, 21'h06E1, 21'h06E2, 21'h06E3,
            21'h06E4, 21'h06E7, 21'h06E8, 21'h06EA, 21'h06EB, 21'h06EC, 21'h06ED:
                m = 1'b1;
            default:
                m = 1'b0;
        endcase
        return m;
    endfunction

    function automatic logic [CP_W-1:0] shape(input form_t f, input logic join_before,
                                              input logic after);
        logic [15:0] r;
        if (join_before && after && f.med != 16'h0)
            r = f.med;
        else if (join_before && f.fin != 16'h0)
            r = f.fin;
        else if (after && f.ini != 16'h0)
            r = f.ini;
        else
            r = f.iso;
        return {5'd0, r};
    endfunction

endpackage

// File: sv/aracs_front.sv
module aracs_front #(
    parameter int MARK_DEPTH = aracs_pkg::MARK_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  aracs_pkg::item_word_t  item,
    input  logic                   q_full,
    output logic                   q_push,
    output aracs_pkg::cmd_t        q_cmd
);
    import aracs_pkg::*;

    localparam int CNT_W = $clog2(MARK_DEPTH + 1);

    logic [15:0]      pend_letter_reg, pend_letter_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_jb_reg, pend_jb_next;
    logic             last_jf_reg, last_jf_next;
    logic [CNT_W-1:0] mark_cnt_reg, mark_cnt_next;

    logic [CP_W-1:0] cp;
    form_t           f_in;
    form_t           f_pend;
    logic            new_letter;
    logic [CP_W-1:0] lig;

    assign q_push = item_valid && !q_full;
    assign cp     = item.code_point;
    assign f_in   = form_lookup(cp);
    assign f_pend = form_lookup({5'd0, pend_letter_reg});

    always_comb
    begin
        case (cp)
            CP_ALEF_MADDA:       lig = 21'h00FEF5;
            CP_ALEF_HAMZA_ABOVE: lig = 21'h00FEF7;
            CP_ALEF_HAMZA_BELOW: lig = 21'h00FEF9;
            CP_ALEF:             lig = 21'h00FEFB;
            default:             lig = '0;
        endcase
    end

    always_comb
    begin
        q_cmd            = '0;
        q_cmd.store_idx  = MARK_IDX_W'(mark_cnt_reg);
        q_cmd.store_data = cp[15:0];
        q_cmd.text_end   = item.text_end;
        pend_letter_next = pend_letter_reg;
        pend_valid_next  = pend_valid_reg;
        pend_jb_next     = pend_jb_reg;
        last_jf_next     = last_jf_reg;
        mark_cnt_next    = mark_cnt_reg;
        new_letter       = 1'b0;

        if (is_mark(cp))
        begin
            if (pend_valid_reg)
            begin
                if (mark_cnt_reg == CNT_W'(MARK_DEPTH))
                begin
                    // Buffer full: cut the context and drain everything.
                    q_cmd.overflow  = 1'b1;
                    q_cmd.has_a     = 1'b1;
                    q_cmd.code_a    = shape(f_pend, pend_jb_reg, 1'b0);
                    q_cmd.n_marks   = MARK_CNT_W'(mark_cnt_reg);
                    q_cmd.has_b     = 1'b1;
                    q_cmd.code_b    = cp;
                    pend_valid_next = 1'b0;
                    mark_cnt_next   = '0;
                    last_jf_next    = 1'b0;
                end
                else
                begin
                    q_cmd.store   = 1'b1;
                    mark_cnt_next = mark_cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                q_cmd.has_b  = 1'b1;
                q_cmd.code_b = cp;
            end
        end
        else
        begin
            if (pend_valid_reg)
            begin
                q_cmd.has_a     = 1'b1;
                q_cmd.n_marks   = MARK_CNT_W'(mark_cnt_reg);
                pend_valid_next = 1'b0;
                mark_cnt_next   = '0;
                if ({5'd0, pend_letter_reg} == CP_LAM && lig != '0)
                begin
                    // Consume the alef into the ligature; step to the final form after a joiner.
                    q_cmd.code_a = lig + {20'd0, pend_jb_reg};
                    last_jf_next = 1'b0;
                end
                else
                begin
                    q_cmd.code_a = shape(f_pend, pend_jb_reg, f_in.jb);
                    new_letter   = 1'b1;
                end
            end
            else
            begin
                new_letter = 1'b1;
            end

            if (new_letter)
            begin
                if (f_in.hit)
                begin
                    pend_letter_next = cp[15:0];
                    pend_valid_next  = 1'b1;
                    pend_jb_next     = last_jf_reg;
                    mark_cnt_next    = '0;
                    last_jf_next     = f_in.jf;
                end
                else
                begin
                    q_cmd.has_b  = 1'b1;
                    q_cmd.code_b = cp;
                    last_jf_next = 1'b0;
                end
            end
        end

        if (item.text_end)
        begin
            if (pend_valid_next)
            begin
                if (q_cmd.has_a)
                begin
                    // Freshly held letter after a flush: no marks behind it yet.
                    q_cmd.has_c  = 1'b1;
                    q_cmd.code_c = shape(f_in, pend_jb_next, 1'b0);
                end
                else
                begin
                    q_cmd.has_a   = 1'b1;
                    q_cmd.code_a  = shape(new_letter ? f_in : f_pend, pend_jb_next, 1'b0);
                    q_cmd.n_marks = MARK_CNT_W'(mark_cnt_next);
                end
            end
            pend_valid_next = 1'b0;
            mark_cnt_next   = '0;
            last_jf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_letter_reg <= '0;
            pend_valid_reg  <= 1'b0;
            pend_jb_reg     <= 1'b0;
            last_jf_reg     <= 1'b0;
            mark_cnt_reg    <= '0;
        end
        else if (q_push)
        begin
            pend_letter_reg <= pend_letter_next;
            pend_valid_reg  <= pend_valid_next;
            pend_jb_reg     <= pend_jb_next;
            last_jf_reg     <= last_jf_next;
            mark_cnt_reg    <= mark_cnt_next;
        end
    end

endmodule

// File: sv/aracs_queue.sv
module aracs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  aracs_pkg::cmd_t push_cmd,
    input  logic            pop,
    output aracs_pkg::cmd_t head_cmd,
    output logic            full,
    output logic            empty
);
    import aracs_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/aracs_back.sv
module aracs_back #(
    parameter int MARK_DEPTH = aracs_pkg::MARK_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  aracs_pkg::cmd_t         head_cmd,
    output logic                    q_pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output aracs_pkg::result_word_t result
);
    import aracs_pkg::*;

    localparam int IDX_W = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;

    logic [15:0]           mark_mem_reg [MARK_DEPTH];
    cmd_t                  cmd_reg, cmd_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    result_word_t          res_reg, res_next;
    logic                  res_valid_reg, res_valid_next;

    logic busy;
    logic emit;

    assign busy         = cmd_reg.has_a || (cmd_reg.n_marks != '0) || cmd_reg.has_b
                          || cmd_reg.has_c;
    assign q_pop        = !busy && !q_empty;
    assign emit         = busy && (!res_valid_reg || !result_stall);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        cmd_next       = cmd_reg;
        rd_idx_next    = rd_idx_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && result_stall;

        if (q_pop)
        begin
            cmd_next    = head_cmd;
            rd_idx_next = '0;
        end
        else if (emit)
        begin
            res_valid_next         = 1'b1;
            res_next.mark_overflow = cmd_reg.overflow;
            if (cmd_reg.has_a)
            begin
                res_next.shaped_code = cmd_reg.code_a;
                res_next.run_last    = (cmd_reg.n_marks == '0) && !cmd_reg.has_b
                                       && !cmd_reg.has_c;
                cmd_next.has_a       = 1'b0;
            end
            else if (cmd_reg.n_marks != '0)
            begin
                res_next.shaped_code = {5'd0, mark_mem_reg[rd_idx_reg]};
                res_next.run_last    = (cmd_reg.n_marks == MARK_CNT_W'(1)) && !cmd_reg.has_b
                                       && !cmd_reg.has_c;
                cmd_next.n_marks     = cmd_reg.n_marks - MARK_CNT_W'(1);
                rd_idx_next          = rd_idx_reg + IDX_W'(1);
            end
            else if (cmd_reg.has_b)
            begin
                res_next.shaped_code = cmd_reg.code_b;
                res_next.run_last    = !cmd_reg.has_c;
                cmd_next.has_b       = 1'b0;
            end
            else
            begin
                res_next.shaped_code = cmd_reg.code_c;
                res_next.run_last    = 1'b1;
                cmd_next.has_c       = 1'b0;
            end
            res_next.text_last = res_next.run_last && cmd_reg.text_end;
        end
    end

    // Store a held mark as its command is loaded, ahead of any read of it.
    always_ff @(posedge clk)
    begin
        if (q_pop && head_cmd.store)
            mark_mem_reg[head_cmd.store_idx[IDX_W-1:0]] <= head_cmd.store_data;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= '0;
            rd_idx_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_reg       <= cmd_next;
            rd_idx_reg    <= rd_idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// File: sv/arabic_contextual_shaper.sv
// Arabic contextual shaper: takes one code point word at a time and returns the shaped
// stream. A front end classifies each word against the letter and mark tables, keeps the
// joining context and the held letter, and turns the word into one command; a two-entry
// command queue feeds the back end, which stores held marks in a small mark buffer and
// plays out the results of each command through a registered output stage. The back end
// loads a command only once the last one is played out, then gives one result per cycle
// while result_stall is low; a word gives up to MARK_DEPTH + 2 results. Words whose
// results are delayed (a held letter) produce nothing until the next non-mark word, a
// mark that overflows the buffer or text end; run_last marks the last result of a word.
module arabic_contextual_shaper #(
    parameter int MARK_DEPTH = aracs_pkg::MARK_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  aracs_pkg::item_word_t   item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output aracs_pkg::result_word_t result
);
    import aracs_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Hold the source while the command queue is full.
    assign item_stall = q_full;

    aracs_front #(
        .MARK_DEPTH (MARK_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    aracs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    aracs_back #(
        .MARK_DEPTH (MARK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .head_cmd     (head_cmd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Text end only ever closes a word's run of results.
    a_text_last_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.text_last |-> result.run_last)
        else $error("text_last without run_last");

    // Never pop an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty command queue");

    // A word is taken into the queue only when room is there.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full command queue");

endmodule

// File: test/arabic_contextual_shaper_tb.sv
`timescale 1ns / 100ps

// Testbench for the Arabic contextual shaper. Code point words go in through a
// valid/stall channel; a local model of the shaper predicts every result word,
// and a checker compares each accepted result word field by field against the
// oldest prediction. Directed texts come first, then random texts in four
// phases of source idling and result stalling.
module arabic_contextual_shaper_tb;
    import aracs_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int DEPTH       = MARK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_stall;
    item_word_t   item;
    logic         result_valid;
    logic         result_stall;
    result_word_t result;

    // Idle and stall probabilities, in percent.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // Shaper state as the model keeps it.
    logic [CP_W-1:0] held_letter;
    logic            held_letter_valid;
    logic            held_joined_before;
    logic            prev_joins_fwd;
    logic [15:0]     held_mark_buf [DEPTH];
    int              held_mark_cnt;

    result_word_t shaped_queue [$];
    int           error_count;
    int           words_sent;
    int           results_seen;
    int           overflow_seen;
    int           ligature_seen;
    longint       cycle_count;

    // Mark table copy for picking stimulus.
    logic [15:0] mark_list [39] = '{
        16'h0610, 16'h0612, 16'h0613, 16'h0614, 16'h0615, 16'h064B, 16'h064C, 16'h064D,
        16'h064E, 16'h064F, 16'h0650, 16'h0651, 16'h0652, 16'h0653, 16'h0654, 16'h0655,
        16'h0656, 16'h0657, 16'h0658, 16'h0670, 16'h06D6, 16'h06D7, 16'h06D8, 16'h06D9,
        16'h06DA, 16'h06DB, 16'h06DC, 16'h06DF, 16'h06E0, 16'h06E1, 16'h06E2, 16'h06E3,
        16'h06E4, 16'h06E7, 16'h06E8, 16'h06EA, 16'h06EB, 16'h06EC, 16'h06ED
    };

    // Letter table copy: code, isolated, initial, medial, final.
    logic [15:0] letter_list [49][5] = '{
        '{16'h0621, 16'hFE80, 16'h0, 16'h0, 16'h0},
        '{16'h0622, 16'hFE81, 16'h0, 16'h0, 16'hFE82},
        '{16'h0623, 16'hFE83, 16'h0, 16'h0, 16'hFE84},
        '{16'h0624, 16'hFE85, 16'h0, 16'h0, 16'hFE86},
        '{16'h0625, 16'hFE87, 16'h0, 16'h0, 16'hFE88},
        '{16'h0626, 16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A},
        '{16'h0627, 16'hFE8D, 16'h0, 16'h0, 16'hFE8E},
        '{16'h0628, 16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90},
        '{16'h0629, 16'hFE93, 16'h0, 16'h0, 16'hFE94},
        '{16'h062A, 16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96},
        '{16'h062B, 16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A},
        '{16'h062C, 16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E},
        '{16'h062D, 16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2},
        '{16'h062E, 16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6},
        '{16'h062F, 16'hFEA9, 16'h0, 16'h0, 16'hFEAA},
        '{16'h0630, 16'hFEAB, 16'h0, 16'h0, 16'hFEAC},
        '{16'h0631, 16'hFEAD, 16'h0, 16'h0, 16'hFEAE},
        '{16'h0632, 16'hFEAF, 16'h0, 16'h0, 16'hFEB0},
        '{16'h0633, 16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2},
        '{16'h0634, 16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6},
        '{16'h0635, 16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA},
        '{16'h0636, 16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE},
        '{16'h0637, 16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2},
        '{16'h0638, 16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6},
        '{16'h0639, 16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA},
        '{16'h063A, 16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE},
        '{16'h0640, 16'h0640, 16'h0, 16'h0, 16'h0},
        '{16'h0641, 16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2},
        '{16'h0642, 16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6},
        '{16'h0643, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA},
        '{16'h0644, 16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE},
        '{16'h0645, 16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2},
        '{16'h0646, 16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6},
        '{16'h0647, 16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA},
        '{16'h0648, 16'hFEED, 16'h0, 16'h0, 16'hFEEE},
        '{16'h0649, 16'hFEEF, 16'hFEF3, 16'hFEF4, 16'hFEF0},
        '{16'h064A, 16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2},
        '{16'h0679, 16'hFB66, 16'hFB68, 16'hFB69, 16'hFB67},
        '{16'h067E, 16'hFB56, 16'hFB58, 16'hFB59, 16'hFB57},
        '{16'h0686, 16'hFB7A, 16'hFB7C, 16'hFB7D, 16'hFB7B},
        '{16'h0688, 16'hFB88, 16'h0, 16'h0, 16'hFB89},
        '{16'h0691, 16'hFB8C, 16'h0, 16'h0, 16'hFB8D},
        '{16'h0698, 16'hFB8A, 16'h0, 16'h0, 16'hFB8B},
        '{16'h06A9, 16'hFB8E, 16'hFB90, 16'hFB91, 16'hFB8F},
        '{16'h06AF, 16'hFB92, 16'hFB94, 16'hFB95, 16'hFB93},
        '{16'h06BA, 16'hFB9E, 16'hFEE7, 16'hFEE8, 16'hFB9F},
        '{16'h06BE, 16'hFBAA, 16'hFBAC, 16'hFBAD, 16'hFBAB},
        '{16'h06C1, 16'hFBA6, 16'hFBA8, 16'hFBA9, 16'hFBA7},
        '{16'h06CC, 16'hFEEF, 16'hFEF3, 16'hFEF4, 16'hFEF0}
    };

    arabic_contextual_shaper i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Model of the shaper
    // ---------------------------------------------------------------------

    // Index of a letter in the form table, -1 if not a letter.
    function automatic int letter_index(input logic [CP_W-1:0] cp);
        for (int i = 0; i < 49; i++)
            if (cp == {5'd0, letter_list[i][0]})
                return i;
        return -1;
    endfunction

    function automatic bit mark_code(input logic [CP_W-1:0] cp);
        for (int i = 0; i < 39; i++)
            if (cp == {5'd0, mark_list[i]})
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit links_forward(input logic [CP_W-1:0] cp);
        int idx;
        idx = letter_index(cp);
        if (idx < 0)
            return 1'b0;
        return cp == CP_TATWEEL || letter_list[idx][2] != 0 || letter_list[idx][3] != 0;
    endfunction

    function automatic bit links_backward(input logic [CP_W-1:0] cp);
        int idx;
        idx = letter_index(cp);
        if (idx < 0)
            return 1'b0;
        return cp == CP_TATWEEL || letter_list[idx][3] != 0 || letter_list[idx][4] != 0;
    endfunction

    // Isolated lam-alef ligature code, or 0 when cp is no alef variant.
    function automatic logic [CP_W-1:0] ligature_base(input logic [CP_W-1:0] cp);
        case (cp)
            CP_ALEF_MADDA:       return 21'h00FEF5;
            CP_ALEF_HAMZA_ABOVE: return 21'h00FEF7;
            CP_ALEF_HAMZA_BELOW: return 21'h00FEF9;
            CP_ALEF:             return 21'h00FEFB;
            default:             return '0;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] letter_form(input logic [CP_W-1:0] cp,
                                                    input bit join_before, input bit after);
        int idx;
        idx = letter_index(cp);
        if (idx < 0)
            return cp;
        if (join_before && after && letter_list[idx][3] != 0)
            return {5'd0, letter_list[idx][3]};
        if (join_before && letter_list[idx][4] != 0)
            return {5'd0, letter_list[idx][4]};
        if (after && letter_list[idx][2] != 0)
            return {5'd0, letter_list[idx][2]};
        return {5'd0, letter_list[idx][1]};
    endfunction

    // Release the held letter, shaped by its context, then its marks.
    task automatic release_letter(inout logic [CP_W-1:0] codes[$], input bit after);
        if (!held_letter_valid)
            return;
        codes.push_back(letter_form(held_letter, held_joined_before, after));
        for (int i = 0; i < held_mark_cnt; i++)
            codes.push_back({5'd0, held_mark_buf[i]});
        held_mark_cnt     = 0;
        held_letter_valid = 1'b0;
    endtask

    // Advance the model by one accepted word and queue the results it causes.
    task automatic shape_word(input item_word_t w);
        logic [CP_W-1:0] codes[$];
        bit              overflow;
        bit              consumed;
        result_word_t    r;

        overflow = 1'b0;
        consumed = 1'b0;
        if (mark_code(w.code_point))
        begin
            if (held_letter_valid)
            begin
                if (held_mark_cnt >= DEPTH)
                begin
                    overflow = 1'b1;
                    release_letter(codes, 1'b0);
                    codes.push_back(w.code_point);
                    prev_joins_fwd = 1'b0;
                end
                else
                begin
                    held_mark_buf[held_mark_cnt] = w.code_point[15:0];
                    held_mark_cnt++;
                end
            end
            else
                codes.push_back(w.code_point);
        end
        else
        begin
            if (held_letter_valid)
            begin
                if (held_letter == CP_LAM && ligature_base(w.code_point) != 0)
                begin
                    // Lam and alef fold into one ligature; the alef is consumed.
                    codes.push_back(ligature_base(w.code_point) + held_joined_before);
                    for (int i = 0; i < held_mark_cnt; i++)
                        codes.push_back({5'd0, held_mark_buf[i]});
                    held_mark_cnt     = 0;
                    held_letter_valid = 1'b0;
                    prev_joins_fwd    = 1'b0;
                    consumed          = 1'b1;
                    ligature_seen++;
                end
                else
                    release_letter(codes, links_backward(w.code_point));
            end
            if (!consumed)
            begin
                if (letter_index(w.code_point) >= 0)
                begin
                    held_letter        = w.code_point;
                    held_letter_valid  = 1'b1;
                    held_joined_before = prev_joins_fwd;
                    held_mark_cnt      = 0;
                    prev_joins_fwd     = links_forward(w.code_point);
                end
                else
                begin
                    codes.push_back(w.code_point);
                    prev_joins_fwd = 1'b0;
                end
            end
        end

        if (w.text_end)
        begin
            release_letter(codes, 1'b0);
            prev_joins_fwd = 1'b0;
        end

        if (overflow)
            overflow_seen++;
        foreach (codes[i])
        begin
            r.shaped_code   = codes[i];
            r.run_last      = (i == codes.size() - 1);
            r.text_last     = (i == codes.size() - 1) && w.text_end;
            r.mark_overflow = overflow;
            shaped_queue.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------------

    // Send one word; optional idle cycles before it, then hold until accepted.
    // Valid stays high after acceptance until the next call idles or replaces the word.
    task automatic send_word(input logic [CP_W-1:0] cp, input bit last);
        item_word_t w;
        w.code_point = cp;
        w.text_end   = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        shape_word(w);
        words_sent++;
    endtask

    // Drive the stall line at random each cycle.
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_stall_pct);

    // Compare each accepted result word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (shaped_queue.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result word: code %h last %b text %b ovf %b",
                             result.shaped_code, result.run_last, result.text_last,
                             result.mark_overflow);
            end
            else
            begin
                result_word_t want;
                want = shaped_queue.pop_front();
                if (result !== want)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch: expected code %h last %b text %b ovf %b, ",
                                  "got code %h last %b text %b ovf %b"},
                                 want.shaped_code, want.run_last, want.text_last,
                                 want.mark_overflow, result.shaped_code, result.run_last,
                                 result.text_last, result.mark_overflow);
                end
            end
        end
    end

    // Hard limit on run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic logic [CP_W-1:0] any_letter();
        return {5'd0, letter_list[$urandom_range(48)][0]};
    endfunction

    function automatic logic [CP_W-1:0] any_mark();
        return {5'd0, mark_list[$urandom_range(38)]};
    endfunction

    function automatic logic [CP_W-1:0] any_alef();
        case ($urandom_range(3))
            0:       return CP_ALEF_MADDA;
            1:       return CP_ALEF_HAMZA_ABOVE;
            2:       return CP_ALEF_HAMZA_BELOW;
            default: return CP_ALEF;
        endcase
    endfunction

    // Code outside both tables: half the time printable ASCII, else any 21-bit value so every bit toggles.
    function automatic logic [CP_W-1:0] any_other();
        logic [CP_W-1:0] cp;
        cp = CP_W'($urandom());
        if ($urandom_range(1))
            cp = CP_W'($urandom_range(32, 126));
        while (mark_code(cp) || letter_index(cp) >= 0)
            cp = cp ^ 21'h100000;
        return cp;
    endfunction

    // Drop valid, wait until every predicted word is out, then let the pipeline settle.
    task automatic wait_drain();
        item_valid <= 1'b0;
        while (shaped_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    task automatic test_directed();
        // Initial, medial and final forms in one word run, tatweel included.
        send_word(21'h000628, 1'b0);
        send_word(21'h000628, 1'b0);
        send_word(CP_TATWEEL, 1'b0);
        send_word(21'h000628, 1'b0);
        send_word(21'h00062F, 1'b1);
        // Field extremes; non-letters pass through.
        send_word(21'h000000, 1'b0);
        send_word(21'h1FFFFF, 1'b0);
        send_word(21'h10FFFF, 1'b1);
        // Lam-alef after a joiner, with a mark in between.
        send_word(21'h000628, 1'b0);
        send_word(CP_LAM, 1'b0);
        send_word(21'h00064E, 1'b0);
        send_word(CP_ALEF, 1'b1);
        // Isolated lam-alef.
        send_word(CP_LAM, 1'b0);
        send_word(CP_ALEF_HAMZA_BELOW, 1'b1);
        // Mark with nothing held, then full mark buffer overflow.
        send_word(21'h000610, 1'b0);
        send_word(21'h000628, 1'b0);
        for (int i = 0; i <= DEPTH; i++)
            send_word(21'h0006ED, 1'b0);
        send_word(21'h000628, 1'b1);
        wait_drain();
    endtask

    // One random text: mostly letters and marks, some lam-alef pairs and noise.
    task automatic send_random_text(input int len);
        logic [CP_W-1:0] cp;
        int              kind;
        for (int i = 0; i < len; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 45)
                cp = any_letter();
            else if (kind < 65)
                cp = any_mark();
            else if (kind < 75)
                cp = CP_LAM;
            else if (kind < 85)
                cp = any_alef();
            else if (kind < 90)
                cp = CP_TATWEEL;
            else
                cp = any_other();
            send_word(cp, i == len - 1);
        end
    endtask

    // Letter followed by a burst of marks, sometimes past the buffer depth.
    task automatic send_mark_burst();
        send_word(any_letter(), 1'b0);
        repeat ($urandom_range(DEPTH + 2)) send_word(any_mark(), 1'b0);
        send_word(any_letter(), 1'($urandom_range(1)));
    endtask

    task automatic test_random_phase(input int unsigned idle_pct,
                                     input int unsigned stall_pct, input int words);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (words > 0)
        begin
            if ($urandom_range(3) == 0)
            begin
                send_mark_burst();
                words -= 6;
            end
            else
            begin
                int len;
                len = $urandom_range(1, 10);
                send_random_text(len);
                words -= len;
            end
        end
        // Close the text so the held letter is released.
        send_word(any_other(), 1'b1);
        wait_drain();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        item_valid         = 1'b0;
        item               = '0;
        result_stall       = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        held_letter        = '0;
        held_letter_valid  = 1'b0;
        held_joined_before = 1'b0;
        prev_joins_fwd     = 1'b0;
        held_mark_cnt      = 0;
        error_count        = 0;
        words_sent         = 0;
        results_seen       = 0;
        overflow_seen      = 0;
        ligature_seen      = 0;
        cycle_count        = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 55);
        test_random_phase(72, 0, 50);
        test_random_phase(0, 72, 50);
        test_random_phase(36, 36, 50);

        $display("sent %0d code point words, checked %0d result words", words_sent,
                 results_seen);
        $display("%0d lam-alef ligatures, %0d mark buffer overflows", ligature_seen,
                 overflow_seen);
        if (error_count == 0 && shaped_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches, %0d results missing", error_count,
                     shaped_queue.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
